FILE: rtl/wsep_pkg.sv
// Shared types and constants for the WLAN security element parser.
package wsep_pkg;

    localparam int unsigned N_RSN_AKM = 6;
    localparam int unsigned N_WPA_AKM = 2;

    localparam logic [7:0]  ID_RSN       = 8'd48;
    localparam logic [7:0]  ID_VEND      = 8'd221;
    localparam logic [31:0] WPA_OUI_TYPE = 32'h01F2_5000;
    localparam logic [15:0] RSN_VERSION  = 16'h0001;

    localparam logic [31:0] RSN_AKM_SUITES [N_RSN_AKM] = '{
        32'h01ac_0f00, 32'h02ac_0f00, 32'h03ac_0f00,
        32'h04ac_0f00, 32'h05ac_0f00, 32'h06ac_0f00
    };
    localparam logic [31:0] WPA_AKM_SUITES [N_WPA_AKM] = '{
        32'h01f2_5000, 32'h02f2_5000
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       element_last;
        logic       frame_last;
        logic       privacy;
    } in_word_t;

    typedef struct packed {
        logic                 rsn_present;
        logic                 wpa_present;
        logic                 wep_only;
        logic [N_RSN_AKM-1:0] rsn_akm_mask;
        logic [N_WPA_AKM-1:0] wpa_akm_mask;
        logic                 parse_error;
    } out_word_t;

    // Classified word handed from the front end to the parser.
    typedef struct packed {
        in_word_t raw;
        logic     is_rsn_id;
        logic     is_vend_id;
        logic     elem_end;
    } cls_word_t;

endpackage

FILE: rtl/wsep_front.sv
// Front end: accepts input words, classifies them and queues them for the parser.
module wsep_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wsep_pkg::in_word_t  s_data,
    output logic                q_valid,
    input  logic                q_ready,
    output wsep_pkg::cls_word_t q_word
);

    wsep_pkg::cls_word_t fifo_reg [2];
    wsep_pkg::cls_word_t cls_word;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    always_comb begin
        cls_word.raw        = s_data;
        cls_word.is_rsn_id  = (s_data.data_byte == wsep_pkg::ID_RSN);
        cls_word.is_vend_id = (s_data.data_byte == wsep_pkg::ID_VEND);
        cls_word.elem_end   = s_data.element_last | s_data.frame_last;
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_word  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cls_word;
        end
    end

endmodule

FILE: rtl/wsep_back.sv
// Back end: element parser state machine and registered result word.
module wsep_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  wsep_pkg::cls_word_t  q_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wsep_pkg::out_word_t  m_data
);

    localparam logic [3:0] PH_ID    = 4'd0;
    localparam logic [3:0] PH_LEN   = 4'd1;
    localparam logic [3:0] PH_OUI   = 4'd2;
    localparam logic [3:0] PH_VER   = 4'd3;
    localparam logic [3:0] PH_GRP   = 4'd4;
    localparam logic [3:0] PH_PCNT  = 4'd5;
    localparam logic [3:0] PH_PLIST = 4'd6;
    localparam logic [3:0] PH_ACNT  = 4'd7;
    localparam logic [3:0] PH_ALIST = 4'd8;
    localparam logic [3:0] PH_DONE  = 4'd9;
    localparam logic [3:0] PH_SKIP  = 4'd10;
    localparam logic [3:0] PH_HALT  = 4'd11;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RSN  = 2'd1;
    localparam logic [1:0] KIND_VEND = 2'd2;

    logic [3:0]  phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [1:0]  pos_reg, pos_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [31:0] word_reg, word_next;
    logic        rsn_flag_reg, rsn_flag_next;
    logic        wpa_flag_reg, wpa_flag_next;
    logic        err_reg, err_next;
    logic [wsep_pkg::N_RSN_AKM-1:0] rsn_mask_reg, rsn_mask_next;
    logic [wsep_pkg::N_WPA_AKM-1:0] wpa_mask_reg, wpa_mask_next;
    logic                m_valid_reg, m_valid_next;
    wsep_pkg::out_word_t m_data_reg, m_data_next;

    logic        consume, gather, last4, last2;
    logic [31:0] word_asm;
    logic [15:0] cnt_dec;
    logic [2:0]  pos_inc;
    logic [wsep_pkg::N_RSN_AKM-1:0] rsn_hit;
    logic [wsep_pkg::N_WPA_AKM-1:0] wpa_hit;

    assign q_ready = !m_valid_reg || m_ready;
    assign consume = q_valid && q_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign last4   = (pos_reg == 2'd3);
    assign last2   = (pos_reg == 2'd1);
    assign pos_inc = {1'b0, pos_reg} + 3'd1;
    assign cnt_dec = cnt_reg - 16'd1;
    assign gather  = phase_reg inside {PH_OUI, PH_VER, PH_PCNT, PH_ACNT, PH_ALIST};

    // little-endian field assembly, cleared on the first byte of each field
    assign word_asm = ((pos_reg == 2'd0) ? 32'h0 : word_reg)
                    | ({24'h0, q_word.raw.data_byte} << {pos_reg, 3'b000});

    always_comb begin
        for (int i = 0; i < wsep_pkg::N_RSN_AKM; i++) begin
            rsn_hit[i] = (word_asm == wsep_pkg::RSN_AKM_SUITES[i]);
        end
        for (int j = 0; j < wsep_pkg::N_WPA_AKM; j++) begin
            wpa_hit[j] = (word_asm == wsep_pkg::WPA_AKM_SUITES[j]);
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        kind_next     = kind_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        word_next     = word_reg;
        rsn_flag_next = rsn_flag_reg;
        wpa_flag_next = wpa_flag_reg;
        err_next      = err_reg;
        rsn_mask_next = rsn_mask_reg;
        wpa_mask_next = wpa_mask_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (consume) begin
            // byte step
            if (q_word.raw.has_byte && phase_reg != PH_HALT) begin
                if (gather) begin
                    word_next = word_asm;
                end
                case (phase_reg)
                    PH_ID: begin
                        kind_next  = q_word.is_rsn_id ? KIND_RSN :
                                     q_word.is_vend_id ? KIND_VEND : KIND_NONE;
                        phase_next = PH_LEN;
                        pos_next   = 2'd0;
                    end
                    PH_LEN: begin
                        phase_next = (kind_reg == KIND_RSN) ? PH_VER :
                                     (kind_reg == KIND_VEND) ? PH_OUI : PH_SKIP;
                        pos_next   = 2'd0;
                    end
                    PH_OUI: begin
                        if (last4) begin
                            phase_next = (word_asm == wsep_pkg::WPA_OUI_TYPE) ? PH_VER : PH_SKIP;
                        end
                        pos_next = last4 ? 2'd0 : pos_inc[1:0];
                    end
                    PH_VER: begin
                        if (last2 && word_asm[15:0] != wsep_pkg::RSN_VERSION) begin
                            err_next   = 1'b1;
                            phase_next = PH_HALT;
                        end else begin
                            if (last2) begin
                                phase_next = PH_GRP;
                            end
                            pos_next = last2 ? 2'd0 : pos_inc[1:0];
                        end
                    end
                    PH_GRP: begin
                        if (last4) begin
                            phase_next = PH_PCNT;
                        end
                        pos_next = last4 ? 2'd0 : pos_inc[1:0];
                    end
                    PH_PCNT: begin
                        if (last2) begin
                            cnt_next   = word_asm[15:0];
                            phase_next = (word_asm[15:0] != 16'd0) ? PH_PLIST : PH_ACNT;
                        end
                        pos_next = last2 ? 2'd0 : pos_inc[1:0];
                    end
                    PH_PLIST: begin
                        if (last4) begin
                            cnt_next = cnt_dec;
                            if (cnt_dec == 16'd0) begin
                                phase_next = PH_ACNT;
                            end
                        end
                        pos_next = last4 ? 2'd0 : pos_inc[1:0];
                    end
                    PH_ACNT: begin
                        if (last2) begin
                            cnt_next = word_asm[15:0];
                            if (word_asm[15:0] == 16'd0) begin
                                // empty AKM list means EAP
                                if (kind_reg == KIND_RSN) begin
                                    rsn_mask_next[0] = 1'b1;
                                end else begin
                                    wpa_mask_next[0] = 1'b1;
                                end
                                phase_next = PH_DONE;
                            end else begin
                                phase_next = PH_ALIST;
                            end
                        end
                        pos_next = last2 ? 2'd0 : pos_inc[1:0];
                    end
                    PH_ALIST: begin
                        if (last4) begin
                            if (kind_reg == KIND_RSN) begin
                                rsn_mask_next = rsn_mask_reg | rsn_hit;
                            end else begin
                                wpa_mask_next = wpa_mask_reg | wpa_hit;
                            end
                            cnt_next = cnt_dec;
                            if (cnt_dec == 16'd0) begin
                                phase_next = PH_DONE;
                            end
                        end
                        pos_next = last4 ? 2'd0 : pos_inc[1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // element end
            if (q_word.elem_end && phase_next != PH_ID && phase_next != PH_HALT) begin
                if (phase_next inside {[PH_VER:PH_ALIST]} ||
                    (phase_next == PH_LEN && kind_next == KIND_RSN)) begin
                    err_next   = 1'b1;
                    phase_next = PH_HALT;
                end else begin
                    if (phase_next == PH_DONE) begin
                        if (kind_next == KIND_RSN) begin
                            rsn_flag_next = 1'b1;
                        end else begin
                            wpa_flag_next = 1'b1;
                        end
                    end
                    phase_next = PH_ID;
                    kind_next  = KIND_NONE;
                    pos_next   = 2'd0;
                    cnt_next   = 16'd0;
                    word_next  = 32'h0;
                end
            end

            // frame end: emit result, back to reset state
            if (q_word.raw.frame_last) begin
                m_valid_next = 1'b1;
                if (err_next) begin
                    m_data_next             = '0;
                    m_data_next.parse_error = 1'b1;
                end else begin
                    m_data_next.rsn_present  = rsn_flag_next;
                    m_data_next.wpa_present  = wpa_flag_next;
                    m_data_next.wep_only     = q_word.raw.privacy && !rsn_flag_next
                                               && !wpa_flag_next;
                    m_data_next.rsn_akm_mask = rsn_mask_next;
                    m_data_next.wpa_akm_mask = wpa_mask_next;
                    m_data_next.parse_error  = 1'b0;
                end
                phase_next    = PH_ID;
                kind_next     = KIND_NONE;
                pos_next      = 2'd0;
                cnt_next      = 16'd0;
                word_next     = 32'h0;
                rsn_flag_next = 1'b0;
                wpa_flag_next = 1'b0;
                err_next      = 1'b0;
                rsn_mask_next = '0;
                wpa_mask_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_ID;
            kind_reg     <= KIND_NONE;
            pos_reg      <= 2'd0;
            cnt_reg      <= 16'd0;
            word_reg     <= 32'h0;
            rsn_flag_reg <= 1'b0;
            wpa_flag_reg <= 1'b0;
            err_reg      <= 1'b0;
            rsn_mask_reg <= '0;
            wpa_mask_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            kind_reg     <= kind_next;
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            word_reg     <= word_next;
            rsn_flag_reg <= rsn_flag_next;
            wpa_flag_reg <= wpa_flag_next;
            err_reg      <= err_next;
            rsn_mask_reg <= rsn_mask_next;
            wpa_mask_reg <= wpa_mask_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

FILE: rtl/wlan_security_element_parser.sv
// Top level: RSN / WPA element parser, front end queue plus parser back end.
// A frame-end word's result is registered: m_valid rises at the edge the parser consumes it.
// One word per cycle save m_ready stalls; the two-entry queue and output register decouple sides.
// One result word per frame, raised on the word that carries frame_last.
// Reset: synchronous, active low; empties the queue, returns the parser to the element id
// state with all frame flags clear and drops m_valid.
module wlan_security_element_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wsep_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wsep_pkg::out_word_t m_data
);

    logic                q_valid;
    logic                q_ready;
    wsep_pkg::cls_word_t q_word;

    wsep_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_word  (q_word)
    );

    wsep_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_word  (q_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a fresh result only follows a consumed frame-end word
    a_result_from_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(q_valid && q_ready && q_word.raw.frame_last))
        else $error("result raised without a frame-end word");

    // error results carry nothing else
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.parse_error) |->
        (!m_data.rsn_present && !m_data.wpa_present && !m_data.wep_only &&
         m_data.rsn_akm_mask == '0 && m_data.wpa_akm_mask == '0))
        else $error("error result with other fields set");

    // WEP only excludes RSN and WPA
    a_wep_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.wep_only) |-> (!m_data.rsn_present && !m_data.wpa_present))
        else $error("wep_only together with RSN or WPA");

    // queue holds its head word while the parser side is backed up and the queue is full
    a_queue_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !q_ready && !s_ready) |=> (q_valid && $stable(q_word)))
        else $error("queued word lost while stalled");

endmodule
